/* hdl/dfr_pkg.sv */
// package for the serial frame deframer: types, register indexes, defaults
`default_nettype none

package dfr_pkg;

    localparam int MAX_DATA_DEFAULT = 8;
    localparam int NUM_SLOTS        = 8;

    localparam logic [7:0] START_MARKER_RESET = 8'd2;
    localparam logic [7:0] END_MARKER_RESET   = 8'd3;
    localparam logic [3:0] FRAME_LEN_RESET    = 4'd9;

    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_END_MARKER   = 2'd1,
        CFG_FRAME_LEN    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_ID1  = 3'd2,
        PH_ID2  = 3'd3,
        PH_DATA = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [3:0] frame_len;
    } dfr_cfg_t;

    typedef struct packed {
        logic [8:0]                     frame_id;
        logic [NUM_SLOTS-1:0][7:0]      data;
    } dfr_result_t;

endpackage

`default_nettype wire

/* hdl/serial_can_frame_deframer_unit.sv */
// top level of the serial frame deframer
`default_nettype none

// Parses a byte stream into fixed-length frames: start marker, length byte
// equal to the configured frame length, two id bytes, frame length - 1 data
// bytes, end marker.
// One byte is taken every clock cycle. A good end marker produces one result
// transaction (id sum and data slots 0..7) registered in the next cycle; the
// input stalls only while that result register is full and m_ready is low.
// Configuration writes take effect at the next byte and should be made idle.
module serial_can_frame_deframer_unit #(
    parameter int MAX_DATA = dfr_pkg::MAX_DATA_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [8:0]      m_frame_id,
    output logic [7:0]      m_data_0,
    output logic [7:0]      m_data_1,
    output logic [7:0]      m_data_2,
    output logic [7:0]      m_data_3,
    output logic [7:0]      m_data_4,
    output logic [7:0]      m_data_5,
    output logic [7:0]      m_data_6,
    output logic [7:0]      m_data_7
);
    import dfr_pkg::*;

    dfr_cfg_t    cfg_reg;
    dfr_result_t res, res_out;
    logic        res_valid;
    logic        byte_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= START_MARKER_RESET;
            cfg_reg.end_marker   <= END_MARKER_RESET;
            cfg_reg.frame_len    <= FRAME_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_MARKER: cfg_reg.start_marker <= cfg_wdata;
                CFG_END_MARKER:   cfg_reg.end_marker   <= cfg_wdata;
                CFG_FRAME_LEN:    cfg_reg.frame_len    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign byte_accept = s_valid && s_ready;

    dfr_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    dfr_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .res_in     (res),
        .can_accept (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .res_out    (res_out)
    );

    assign m_frame_id = res_out.frame_id;
    assign m_data_0   = res_out.data[0];
    assign m_data_1   = res_out.data[1];
    assign m_data_2   = res_out.data[2];
    assign m_data_3   = res_out.data[3];
    assign m_data_4   = res_out.data[4];
    assign m_data_5   = res_out.data[5];
    assign m_data_6   = res_out.data[6];
    assign m_data_7   = res_out.data[7];

endmodule

`default_nettype wire

/* hdl/dfr_parser.sv */
// frame parser: phase state machine, byte index, id sum and data buffer
`default_nettype none

module dfr_parser #(
    parameter int MAX_DATA = dfr_pkg::MAX_DATA_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dfr_pkg::dfr_cfg_t cfg,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        rx_byte,
    output logic                   res_valid,
    output dfr_pkg::dfr_result_t   res
);
    import dfr_pkg::*;

    // only slots that reach the outputs are stored
    localparam int BUF_DEPTH = (MAX_DATA < NUM_SLOTS) ? MAX_DATA : NUM_SLOTS;

    phase_t      phase_reg, phase_next;
    logic [3:0]  index_reg, index_next;
    logic [8:0]  id_reg, id_next;
    logic [7:0]  buf_reg [BUF_DEPTH];
    logic        buf_we;
    logic [3:0]  index_inc;

    assign index_inc = index_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        id_next    = id_reg;
        buf_we     = 1'b0;
        res_valid  = 1'b0;
        unique case (phase_reg)
            PH_LEN: begin
                if (rx_byte == {4'd0, cfg.frame_len}) begin
                    index_next = 4'd0;
                    phase_next = PH_ID1;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_ID1: begin
                id_next    = {1'b0, rx_byte};
                phase_next = PH_ID2;
            end
            PH_ID2: begin
                id_next    = id_reg + {1'b0, rx_byte};
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                buf_we     = 1'b1;
                index_next = index_inc;
                if (index_inc == (cfg.frame_len - 4'd1)) begin
                    phase_next = PH_END;
                end
            end
            PH_END: begin
                phase_next = PH_HUNT;
                res_valid  = byte_accept && (rx_byte == cfg.end_marker);
            end
            default: begin
                phase_next = (rx_byte == cfg.start_marker) ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            index_reg <= 4'd0;
            id_reg    <= 9'd0;
        end else if (byte_accept) begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            id_reg    <= id_next;
        end
    end

    for (genvar k = 0; k < BUF_DEPTH; k++) begin : g_buf
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                buf_reg[k] <= 8'd0;
            end else if (byte_accept && buf_we && index_reg == 4'(k)) begin
                buf_reg[k] <= rx_byte;
            end
        end
    end

    assign res.frame_id = id_reg;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
        if (k < BUF_DEPTH) begin : g_live
            assign res.data[k] = buf_reg[k];
        end else begin : g_zero
            assign res.data[k] = 8'd0;
        end
    end

endmodule

`default_nettype wire

/* hdl/dfr_out_reg.sv */
// result register holding one frame transaction until the consumer takes it
`default_nettype none

module dfr_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire dfr_pkg::dfr_result_t res_in,
    output logic                      can_accept,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dfr_pkg::dfr_result_t      res_out
);
    import dfr_pkg::*;

    logic        valid_reg;
    dfr_result_t res_reg;

    assign can_accept = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire
